// ----- rtl/smp_core_control_unit_core_defines.svh -----
// Assertion macros for the multi-core control unit.
// Used by rtl/smp_core_control_unit_core.sv; no other dependencies.
`ifndef SMP_CORE_CONTROL_UNIT_CORE_DEFINES_SVH
`define SMP_CORE_CONTROL_UNIT_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SMPCU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smpcu assertion failed");
`define SMPCU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smpcu assertion failed");
`else
`define SMPCU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SMPCU_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/smpcu_pkg.sv -----
// Package for the multi-core control unit: operation codes, register offsets,
// reset values and default configuration. No dependencies.
package smpcu_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_PERIPH = 2'd2,
        OP_TIMER  = 2'd3
    } t_op;

    localparam int NUM_CORES_DEF = 2;

    localparam logic [12:0] OFF_SLEEP_CTRL    = 13'h000;
    localparam logic [12:0] OFF_SLEEP_STATUS  = 13'h020;
    localparam logic [12:0] OFF_SOFT_RESET    = 13'h040;
    localparam logic [12:0] OFF_MISC_CTRL     = 13'h060;
    localparam logic [12:0] OFF_ID            = 13'h064;
    localparam logic [12:0] OFF_CORE_COUNT    = 13'h070;
    localparam logic [12:0] OFF_PERIPH_PEND   = 13'h100;
    localparam logic [12:0] OFF_PERIPH_MASK   = 13'h120;
    localparam logic [12:0] OFF_MBOX_PEND     = 13'h140;
    localparam logic [12:0] OFF_MBOX_MASK     = 13'h160;
    localparam logic [12:0] OFF_TIMER_PEND    = 13'h180;
    localparam logic [12:0] OFF_TIMER_MASK    = 13'h1a0;
    localparam logic [12:0] OFF_DEBUG_PEND    = 13'h1c0;
    localparam logic [12:0] OFF_DEBUG_MASK    = 13'h1e0;
    localparam logic [12:0] OFF_ENTRY_ADDR    = 13'hf00;
    localparam logic [12:0] OFF_LOCK_WORD     = 13'hfa0;
    localparam logic [12:0] OFF_LOCK_ATTEMPT  = 13'hfa4;
    localparam logic [12:0] OFF_GLOBAL_MASK   = 13'hfc0;
    localparam logic [12:0] OFF_FEATURE_CTRL  = 13'hfe0;
    localparam logic [12:0] OFF_MBOX_BASE     = 13'h1000;
    localparam logic [12:0] OFF_BUS_CTRL      = 13'h1f00;

    localparam logic [31:0] ID_VALUE          = 32'h0000_2000;
    localparam logic [31:0] ENTRY_RESET       = 32'hbfc0_0000;
    localparam logic [31:0] BUS_CTRL_RESET    = 32'h000f_ffff;
    localparam int          LOCK_BIT          = 31;
    localparam int          SRE0_WE_BIT       = 10;

endpackage

// ----- rtl/smp_core_control_unit_core.sv -----
// Multi-core control unit: register bank, mailboxes, spinlock and soft reset.
// Depends on smpcu_pkg and smp_core_control_unit_core_defines.svh.
//
// Usage: drive an item on the i_ ports and raise start. An item is transferred
// at a rising edge where start is high and busy is low. busy never rises, so
// one item can be transferred every cycle.
// Each item gives exactly one result. It appears on the o_ ports in the cycle
// after the transfer, marked by o_valid for that one cycle, and throughput is
// one item per cycle; it is set by the single result register stage after the
// decode and update logic.
// The result carries read data (zero for writes and level changes), the masked
// peripheral, mailbox and timer interrupts, release and hold pulses for cores
// whose soft reset bit fell or rose, the current boot address, and a flag for
// offsets that match no register.
// Reset (i_rst_n low, synchronous) restores every control and mailbox register
// to its reset value and clears o_valid; the result registers are not reset.
// The receiver cannot stall: each result is taken in the cycle it is shown.
`include "smp_core_control_unit_core_defines.svh"

module smp_core_control_unit_core
    import smpcu_pkg::*;
#(
    parameter int NUM_CORES = NUM_CORES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [12:0] i_offset,
    input  logic [31:0] i_wdata,
    input  logic        i_core,
    input  logic        i_level,
    input  logic [1:0]  i_halted_mask,
    output logic        o_valid,
    output logic [31:0] o_read_data,
    output logic [1:0]  o_periph_int,
    output logic [1:0]  o_mbox_int,
    output logic [1:0]  o_timer_irq,
    output logic [1:0]  o_release_mask,
    output logic [1:0]  o_hold_mask,
    output logic [31:0] o_boot_address,
    output logic        o_unknown_access
);

    localparam logic [31:0] CORE_MASK = (NUM_CORES >= 32) ? 32'hffff_ffff :
                                        32'((64'd1 << NUM_CORES) - 64'd1);
    localparam int          MBOX_IW   = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam logic [13:0] MBOX_END  = 14'(int'(OFF_MBOX_BASE) + 4 * NUM_CORES);

    logic                 accept;
    t_op                  op;

    logic [31:0]          r_sleep_ctrl, n_sleep_ctrl;
    logic [31:0]          r_soft_reset, n_soft_reset;
    logic [31:0]          r_misc_ctrl, n_misc_ctrl;
    logic [31:0]          r_periph_mask, n_periph_mask;
    logic [NUM_CORES-1:0] r_mbox_pending, n_mbox_pending;
    logic [31:0]          r_mbox_mask, n_mbox_mask;
    logic [31:0]          r_timer_mask, n_timer_mask;
    logic [31:0]          r_debug_mask, n_debug_mask;
    logic [31:0]          r_entry_address, n_entry_address;
    logic [31:0]          r_lock_word, n_lock_word;
    logic [31:0]          r_lock_attempt, n_lock_attempt;
    logic [31:0]          r_global_mask, n_global_mask;
    logic [31:0]          r_feature_ctrl, n_feature_ctrl;
    logic [31:0]          r_bus_ctrl, n_bus_ctrl;
    logic [31:0]          r_mailbox [NUM_CORES];
    logic [1:0]           r_periph_level, n_periph_level;
    logic [1:0]           r_timer_level, n_timer_level;

    logic                 mbox_hit;
    logic [MBOX_IW-1:0]   mbox_idx;
    logic                 mbox_we;
    logic [31:0]          sre_value;
    logic [31:0]          rdata, rel, hold;
    logic                 unk;
    logic [31:0]          irq_gate;

    logic                 r_valid;
    logic [31:0]          r_read_data;
    logic [1:0]           r_periph_int, r_mbox_int, r_timer_irq;
    logic [1:0]           r_release_mask, r_hold_mask;
    logic [31:0]          r_boot_address;
    logic                 r_unknown_access;

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign op       = t_op'(i_op);
    assign mbox_hit = ({1'b0, i_offset} >= {1'b0, OFF_MBOX_BASE}) &&
                      ({1'b0, i_offset} < MBOX_END) && (i_offset[1:0] == 2'b00);
    assign mbox_idx = i_offset[2 +: MBOX_IW];
    assign sre_value = r_feature_ctrl[SRE0_WE_BIT] ? i_wdata :
                       {i_wdata[31:1], r_soft_reset[0]};

    always_comb begin
        n_sleep_ctrl    = r_sleep_ctrl;
        n_soft_reset    = r_soft_reset;
        n_misc_ctrl     = r_misc_ctrl;
        n_periph_mask   = r_periph_mask;
        n_mbox_pending  = r_mbox_pending;
        n_mbox_mask     = r_mbox_mask;
        n_timer_mask    = r_timer_mask;
        n_debug_mask    = r_debug_mask;
        n_entry_address = r_entry_address;
        n_lock_word     = r_lock_word;
        n_lock_attempt  = r_lock_attempt;
        n_global_mask   = r_global_mask;
        n_feature_ctrl  = r_feature_ctrl;
        n_bus_ctrl      = r_bus_ctrl;
        n_periph_level  = r_periph_level;
        n_timer_level   = r_timer_level;
        mbox_we         = 1'b0;
        rdata           = '0;
        rel             = '0;
        hold            = '0;
        unk             = 1'b0;

        unique case (op)
            OP_READ: begin
                if (mbox_hit) begin
                    rdata = r_mailbox[mbox_idx];
                end else begin
                    unique case (i_offset)
                        OFF_SLEEP_CTRL:   rdata = r_sleep_ctrl;
                        OFF_SLEEP_STATUS: rdata = 32'(i_halted_mask) & ~r_soft_reset & CORE_MASK;
                        OFF_SOFT_RESET:   rdata = r_soft_reset;
                        OFF_MISC_CTRL:    rdata = r_misc_ctrl;
                        OFF_ID:           rdata = ID_VALUE;
                        OFF_CORE_COUNT:   rdata = 32'(NUM_CORES - 1);
                        OFF_PERIPH_PEND:  rdata = 32'(r_periph_level) & CORE_MASK;
                        OFF_PERIPH_MASK:  rdata = r_periph_mask;
                        OFF_MBOX_PEND:    rdata = 32'(r_mbox_pending);
                        OFF_MBOX_MASK:    rdata = r_mbox_mask;
                        OFF_TIMER_PEND:   rdata = 32'(r_timer_level) & CORE_MASK;
                        OFF_TIMER_MASK:   rdata = r_timer_mask;
                        OFF_DEBUG_PEND:   rdata = '0;
                        OFF_DEBUG_MASK:   rdata = r_debug_mask;
                        OFF_ENTRY_ADDR:   rdata = r_entry_address;
                        OFF_LOCK_WORD:    rdata = r_lock_word;
                        OFF_LOCK_ATTEMPT: rdata = r_lock_attempt;
                        OFF_GLOBAL_MASK:  rdata = r_global_mask;
                        OFF_FEATURE_CTRL: rdata = r_feature_ctrl;
                        OFF_BUS_CTRL:     rdata = r_bus_ctrl;
                        default:          unk   = 1'b1;
                    endcase
                end
            end
            OP_WRITE: begin
                if (mbox_hit) begin
                    mbox_we                  = 1'b1;
                    n_mbox_pending[mbox_idx] = |i_wdata;
                end else begin
                    unique case (i_offset)
                        OFF_SLEEP_CTRL:   n_sleep_ctrl    = i_wdata;
                        OFF_SOFT_RESET: begin
                            n_soft_reset = sre_value;
                            rel          = r_soft_reset & ~sre_value & CORE_MASK;
                            hold         = ~r_soft_reset & sre_value & CORE_MASK;
                        end
                        OFF_MISC_CTRL:    n_misc_ctrl     = i_wdata;
                        OFF_PERIPH_MASK:  n_periph_mask   = i_wdata;
                        OFF_MBOX_MASK:    n_mbox_mask     = i_wdata;
                        OFF_TIMER_MASK:   n_timer_mask    = i_wdata;
                        OFF_DEBUG_MASK:   n_debug_mask    = i_wdata;
                        OFF_ENTRY_ADDR:   n_entry_address = i_wdata;
                        OFF_GLOBAL_MASK:  n_global_mask   = i_wdata;
                        OFF_FEATURE_CTRL: n_feature_ctrl  = i_wdata;
                        OFF_BUS_CTRL:     n_bus_ctrl      = i_wdata;
                        OFF_LOCK_WORD: begin
                            if (!i_wdata[LOCK_BIT]) begin
                                n_lock_word = '0;
                            end
                        end
                        OFF_LOCK_ATTEMPT: begin
                            n_lock_attempt = {1'b0, i_wdata[30:0]};
                            if (!r_lock_word[LOCK_BIT]) begin
                                n_lock_word = {1'b1, i_wdata[30:0]};
                            end
                        end
                        OFF_SLEEP_STATUS, OFF_ID, OFF_CORE_COUNT, OFF_PERIPH_PEND,
                        OFF_MBOX_PEND, OFF_TIMER_PEND, OFF_DEBUG_PEND: begin
                        end
                        default:          unk = 1'b1;
                    endcase
                end
            end
            OP_PERIPH: begin
                if (32'(i_core) < 32'(NUM_CORES)) begin
                    n_periph_level[i_core] = i_level;
                end
            end
            OP_TIMER: begin
                if (32'(i_core) < 32'(NUM_CORES)) begin
                    n_timer_level[i_core] = i_level;
                end
            end
            default: begin
            end
        endcase
    end

    assign irq_gate = CORE_MASK & n_global_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sleep_ctrl    <= CORE_MASK;
            r_soft_reset    <= CORE_MASK & ~32'd1;
            r_misc_ctrl     <= '0;
            r_periph_mask   <= 32'd1;
            r_mbox_pending  <= '0;
            r_mbox_mask     <= '0;
            r_timer_mask    <= 32'd1;
            r_debug_mask    <= 32'd1;
            r_entry_address <= ENTRY_RESET;
            r_lock_word     <= '0;
            r_lock_attempt  <= '0;
            r_global_mask   <= CORE_MASK;
            r_feature_ctrl  <= '0;
            r_bus_ctrl      <= BUS_CTRL_RESET;
            r_periph_level  <= '0;
            r_timer_level   <= '0;
            r_valid         <= 1'b0;
        end else begin
            r_valid <= accept;
            if (accept) begin
                r_sleep_ctrl    <= n_sleep_ctrl;
                r_soft_reset    <= n_soft_reset;
                r_misc_ctrl     <= n_misc_ctrl;
                r_periph_mask   <= n_periph_mask;
                r_mbox_pending  <= n_mbox_pending;
                r_mbox_mask     <= n_mbox_mask;
                r_timer_mask    <= n_timer_mask;
                r_debug_mask    <= n_debug_mask;
                r_entry_address <= n_entry_address;
                r_lock_word     <= n_lock_word;
                r_lock_attempt  <= n_lock_attempt;
                r_global_mask   <= n_global_mask;
                r_feature_ctrl  <= n_feature_ctrl;
                r_bus_ctrl      <= n_bus_ctrl;
                r_periph_level  <= n_periph_level;
                r_timer_level   <= n_timer_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CORES; i++) begin
                r_mailbox[i] <= '0;
            end
        end else if (accept && mbox_we) begin
            r_mailbox[mbox_idx] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_read_data      <= rdata;
            r_periph_int     <= n_periph_level & n_periph_mask[1:0] & irq_gate[1:0];
            r_mbox_int       <= 2'(32'(n_mbox_pending) & n_mbox_mask & irq_gate);
            r_timer_irq      <= n_timer_level & n_timer_mask[1:0] & irq_gate[1:0];
            r_release_mask   <= rel[1:0];
            r_hold_mask      <= hold[1:0];
            r_boot_address   <= n_entry_address;
            r_unknown_access <= unk;
        end
    end

    assign o_valid          = r_valid;
    assign o_read_data      = r_read_data;
    assign o_periph_int     = r_periph_int;
    assign o_mbox_int       = r_mbox_int;
    assign o_timer_irq      = r_timer_irq;
    assign o_release_mask   = r_release_mask;
    assign o_hold_mask      = r_hold_mask;
    assign o_boot_address   = r_boot_address;
    assign o_unknown_access = r_unknown_access;

    `SMPCU_ASSERT_NEXT(a_valid_follows_accept, i_clk, i_rst_n, accept, o_valid)
    `SMPCU_ASSERT_NEXT(a_no_spurious_valid, i_clk, i_rst_n, !accept, !o_valid)
    `SMPCU_ASSERT_SAME(a_release_hold_disjoint, i_clk, i_rst_n, o_valid, (o_release_mask & o_hold_mask) == 2'b00)
    `SMPCU_ASSERT_NEXT(a_level_change_quiet, i_clk, i_rst_n, accept && (op == OP_PERIPH || op == OP_TIMER), (o_read_data == 32'd0) && !o_unknown_access)
    `SMPCU_ASSERT_SAME(a_attempt_no_lock_bit, i_clk, i_rst_n, 1'b1, !r_lock_attempt[LOCK_BIT])

endmodule

// ----- verif/smpcu_checker.sv -----
// Checker for the multi-core control unit: predicts each result from the accepted accesses
// and compares it field by field with what the block shows.
// Depends on smpcu_pkg.
module smpcu_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_op,
    input  logic [12:0] i_offset,
    input  logic [31:0] i_wdata,
    input  logic        i_core,
    input  logic        i_level,
    input  logic [1:0]  i_halted_mask,
    input  logic        i_valid,
    input  logic [31:0] i_read_data,
    input  logic [1:0]  i_periph_int,
    input  logic [1:0]  i_mbox_int,
    input  logic [1:0]  i_timer_irq,
    input  logic [1:0]  i_release_mask,
    input  logic [1:0]  i_hold_mask,
    input  logic [31:0] i_boot_address,
    input  logic        i_unknown_access,
    output int          o_error_count,
    output int          o_pending_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import smpcu_pkg::*;

    localparam int          CORES     = NUM_CORES_DEF;
    localparam logic [31:0] CORE_MASK = (32'h1 << CORES) - 32'h1;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  periph_int;
        logic [1:0]  mbox_int;
        logic [1:0]  timer_irq;
        logic [1:0]  release_mask;
        logic [1:0]  hold_mask;
        logic [31:0] boot_address;
        logic        unknown_access;
    } t_access_result;

    logic [31:0] sleep_reg, sreset_reg, misc_reg, pmask_reg, mbox_pend, mbox_mask_reg;
    logic [31:0] tmask_reg, dmask_reg, entry_reg, lock_reg, attempt_reg, gmask_reg;
    logic [31:0] feature_reg, bus_reg, plevel, tlevel;
    logic [31:0] mbox_word [CORES];

    t_access_result access_results_q[$];
    t_access_result want;
    int error_count = 0;

    assign o_error_count = error_count;

    task automatic clear_registers();
        sleep_reg     = CORE_MASK;
        sreset_reg    = CORE_MASK & ~32'h1;
        misc_reg      = '0;
        pmask_reg     = 32'h1;
        mbox_pend     = '0;
        mbox_mask_reg = '0;
        tmask_reg     = 32'h1;
        dmask_reg     = 32'h1;
        entry_reg     = ENTRY_RESET;
        lock_reg      = '0;
        attempt_reg   = '0;
        gmask_reg     = CORE_MASK;
        feature_reg   = '0;
        bus_reg       = BUS_CTRL_RESET;
        plevel        = '0;
        tlevel        = '0;
        for (int n = 0; n < CORES; n++) begin
            mbox_word[n] = '0;
        end
    endtask

    function automatic t_access_result apply_access(t_op op, logic [12:0] off, logic [31:0] wd,
                                                    logic c, logic lv, logic [1:0] halted);
        t_access_result res;
        logic [31:0]    prev;
        logic [31:0]    v;
        logic [31:0]    gm;
        logic           mbox_hit;
        int             idx;
        res      = '0;
        mbox_hit = off >= OFF_MBOX_BASE && off < OFF_MBOX_BASE + 13'(4 * CORES)
                   && off[1:0] == 2'b00;
        idx      = int'((off - OFF_MBOX_BASE) >> 2);
        case (op)
            OP_READ: begin
                if (mbox_hit) begin
                    res.read_data = mbox_word[idx];
                end else begin
                    case (off)
                        OFF_SLEEP_CTRL:   res.read_data = sleep_reg;
                        OFF_SLEEP_STATUS: res.read_data = {30'b0, halted} & ~sreset_reg & CORE_MASK;
                        OFF_SOFT_RESET:   res.read_data = sreset_reg;
                        OFF_MISC_CTRL:    res.read_data = misc_reg;
                        OFF_ID:           res.read_data = ID_VALUE;
                        OFF_CORE_COUNT:   res.read_data = 32'(CORES - 1);
                        OFF_PERIPH_PEND:  res.read_data = plevel & CORE_MASK;
                        OFF_PERIPH_MASK:  res.read_data = pmask_reg;
                        OFF_MBOX_PEND:    res.read_data = mbox_pend;
                        OFF_MBOX_MASK:    res.read_data = mbox_mask_reg;
                        OFF_TIMER_PEND:   res.read_data = tlevel & CORE_MASK;
                        OFF_TIMER_MASK:   res.read_data = tmask_reg;
                        OFF_DEBUG_PEND:   res.read_data = '0;
                        OFF_DEBUG_MASK:   res.read_data = dmask_reg;
                        OFF_ENTRY_ADDR:   res.read_data = entry_reg;
                        OFF_LOCK_WORD:    res.read_data = lock_reg;
                        OFF_LOCK_ATTEMPT: res.read_data = attempt_reg;
                        OFF_GLOBAL_MASK:  res.read_data = gmask_reg;
                        OFF_FEATURE_CTRL: res.read_data = feature_reg;
                        OFF_BUS_CTRL:     res.read_data = bus_reg;
                        default:          res.unknown_access = 1'b1;
                    endcase
                end
            end
            OP_WRITE: begin
                if (mbox_hit) begin
                    mbox_word[idx] = wd;
                    mbox_pend[idx] = (wd != '0);
                end else begin
                    case (off)
                        OFF_SLEEP_CTRL:   sleep_reg = wd;
                        OFF_SOFT_RESET: begin
                            prev = sreset_reg;
                            v = feature_reg[SRE0_WE_BIT] ? wd : {wd[31:1], prev[0]};
                            sreset_reg = v;
                            res.release_mask = 2'(prev & ~v & CORE_MASK);
                            res.hold_mask    = 2'(~prev & v & CORE_MASK);
                        end
                        OFF_MISC_CTRL:    misc_reg = wd;
                        OFF_PERIPH_MASK:  pmask_reg = wd;
                        OFF_MBOX_MASK:    mbox_mask_reg = wd;
                        OFF_TIMER_MASK:   tmask_reg = wd;
                        OFF_DEBUG_MASK:   dmask_reg = wd;
                        OFF_ENTRY_ADDR:   entry_reg = wd;
                        OFF_GLOBAL_MASK:  gmask_reg = wd;
                        OFF_FEATURE_CTRL: feature_reg = wd;
                        OFF_BUS_CTRL:     bus_reg = wd;
                        OFF_LOCK_WORD: begin
                            if (!wd[LOCK_BIT]) begin
                                lock_reg = '0;
                            end
                        end
                        OFF_LOCK_ATTEMPT: begin
                            attempt_reg = {1'b0, wd[30:0]};
                            if (!lock_reg[LOCK_BIT]) begin
                                lock_reg = {1'b1, wd[30:0]};
                            end
                        end
                        OFF_SLEEP_STATUS, OFF_ID, OFF_CORE_COUNT, OFF_PERIPH_PEND,
                        OFF_MBOX_PEND, OFF_TIMER_PEND, OFF_DEBUG_PEND: begin
                        end
                        default:          res.unknown_access = 1'b1;
                    endcase
                end
            end
            default: begin
                if (int'(c) < CORES) begin
                    if (op == OP_PERIPH) begin
                        plevel[c] = lv;
                    end else begin
                        tlevel[c] = lv;
                    end
                end
            end
        endcase
        gm               = CORE_MASK & gmask_reg;
        res.periph_int   = 2'(plevel & pmask_reg & gm);
        res.mbox_int     = 2'(mbox_pend & mbox_mask_reg & gm);
        res.timer_irq    = 2'(tlevel & tmask_reg & gm);
        res.boot_address = entry_reg;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (exp_val !== act_val) begin
            error_count++;
            $display("%0t: %s mismatch, expected 0x%08h, actual 0x%08h",
                     $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_registers();
            access_results_q.delete();
        end else begin
            if (i_valid) begin
                if (access_results_q.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, expected none, actual read_data 0x%08h",
                             $time, i_read_data);
                end else begin
                    want = access_results_q.pop_front();
                    check_field("read_data", want.read_data, i_read_data);
                    check_field("periph_int", 32'(want.periph_int), 32'(i_periph_int));
                    check_field("mbox_int", 32'(want.mbox_int), 32'(i_mbox_int));
                    check_field("timer_irq", 32'(want.timer_irq), 32'(i_timer_irq));
                    check_field("release_mask", 32'(want.release_mask), 32'(i_release_mask));
                    check_field("hold_mask", 32'(want.hold_mask), 32'(i_hold_mask));
                    check_field("boot_address", want.boot_address, i_boot_address);
                    check_field("unknown_access", 32'(want.unknown_access),
                                32'(i_unknown_access));
                end
            end
            if (i_start && !i_busy) begin
                access_results_q.push_back(apply_access(t_op'(i_op), i_offset, i_wdata, i_core,
                                                        i_level, i_halted_mask));
            end
        end
        o_pending_count <= access_results_q.size();
    end

endmodule

// ----- verif/tb_smp_core_control_unit_core.sv -----
// Testbench top for the multi-core control unit: directed and random register accesses and
// level changes with random idle gaps; results are checked by smpcu_checker.
// Depends on smpcu_pkg, smpcu_checker and the RTL top smp_core_control_unit_core.
module tb_smp_core_control_unit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import smpcu_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_op;
    logic [12:0] i_offset;
    logic [31:0] i_wdata;
    logic        i_core;
    logic        i_level;
    logic [1:0]  i_halted_mask;
    logic        o_valid;
    logic [31:0] o_read_data;
    logic [1:0]  o_periph_int;
    logic [1:0]  o_mbox_int;
    logic [1:0]  o_timer_irq;
    logic [1:0]  o_release_mask;
    logic [1:0]  o_hold_mask;
    logic [31:0] o_boot_address;
    logic        o_unknown_access;

    int error_count;
    int pending_count;
    int idle_cycles = 0;
    bit idle_on = 1'b0;

    smp_core_control_unit_core #(
        .NUM_CORES(NUM_CORES_DEF)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_offset(i_offset),
        .i_wdata(i_wdata),
        .i_core(i_core),
        .i_level(i_level),
        .i_halted_mask(i_halted_mask),
        .o_valid(o_valid),
        .o_read_data(o_read_data),
        .o_periph_int(o_periph_int),
        .o_mbox_int(o_mbox_int),
        .o_timer_irq(o_timer_irq),
        .o_release_mask(o_release_mask),
        .o_hold_mask(o_hold_mask),
        .o_boot_address(o_boot_address),
        .o_unknown_access(o_unknown_access)
    );

    smpcu_checker checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_busy(busy),
        .i_op(i_op),
        .i_offset(i_offset),
        .i_wdata(i_wdata),
        .i_core(i_core),
        .i_level(i_level),
        .i_halted_mask(i_halted_mask),
        .i_valid(o_valid),
        .i_read_data(o_read_data),
        .i_periph_int(o_periph_int),
        .i_mbox_int(o_mbox_int),
        .i_timer_irq(o_timer_irq),
        .i_release_mask(o_release_mask),
        .i_hold_mask(o_hold_mask),
        .i_boot_address(o_boot_address),
        .i_unknown_access(o_unknown_access),
        .o_error_count(error_count),
        .o_pending_count(pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [12:0] known_offset(int k);
        case (k)
            0:       return OFF_SLEEP_CTRL;
            1:       return OFF_SLEEP_STATUS;
            2:       return OFF_SOFT_RESET;
            3:       return OFF_MISC_CTRL;
            4:       return OFF_ID;
            5:       return OFF_CORE_COUNT;
            6:       return OFF_PERIPH_PEND;
            7:       return OFF_PERIPH_MASK;
            8:       return OFF_MBOX_PEND;
            9:       return OFF_MBOX_MASK;
            10:      return OFF_TIMER_PEND;
            11:      return OFF_TIMER_MASK;
            12:      return OFF_DEBUG_PEND;
            13:      return OFF_DEBUG_MASK;
            14:      return OFF_ENTRY_ADDR;
            15:      return OFF_LOCK_WORD;
            16:      return OFF_LOCK_ATTEMPT;
            17:      return OFF_GLOBAL_MASK;
            18:      return OFF_FEATURE_CTRL;
            19:      return OFF_BUS_CTRL;
            20:      return OFF_MBOX_BASE;
            default: return OFF_MBOX_BASE + 13'h4;
        endcase
    endfunction

    // One transfer: optional idle gap with start low, then hold the item until accepted.
    task automatic drive_access(input t_op op, input logic [12:0] off, input logic [31:0] wd,
                                input logic c, input logic lv);
        int gap;
        gap = idle_on ? $urandom_range(0, 15) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start         <= 1'b1;
        i_op          <= op;
        i_offset      <= off;
        i_wdata       <= wd;
        i_core        <= c;
        i_level       <= lv;
        i_halted_mask <= 2'($urandom_range(0, 3));
        do @(posedge i_clk); while (busy);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
    endtask

    task automatic random_access();
        int          sel;
        t_op         op;
        logic [12:0] off;
        logic [31:0] wd;
        sel = $urandom_range(0, 99);
        op  = (sel < 35) ? OP_READ : (sel < 75) ? OP_WRITE : (sel < 87) ? OP_PERIPH : OP_TIMER;
        off = ($urandom_range(0, 99) < 85) ? known_offset($urandom_range(0, 21))
                                           : 13'($urandom_range(0, 8188));
        case ($urandom_range(0, 7))
            0:       wd = '0;
            1:       wd = '1;
            2:       wd = 32'($urandom_range(0, 15));
            default: wd = $urandom;
        endcase
        drive_access(op, off, wd, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = '0;
        i_offset      = '0;
        i_wdata       = '0;
        i_core        = 1'b0;
        i_level       = 1'b0;
        i_halted_mask = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        drive_access(OP_READ, OFF_SLEEP_STATUS, '0, 1'b0, 1'b0);
        drive_access(OP_READ, OFF_CORE_COUNT, '0, 1'b0, 1'b0);
        // Core zero's reset bit is protected until the feature bit allows it.
        drive_access(OP_WRITE, OFF_SOFT_RESET, '0, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_SOFT_RESET, '1, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_FEATURE_CTRL, 32'h1 << SRE0_WE_BIT, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_SOFT_RESET, '1, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_SOFT_RESET, '0, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_MBOX_MASK, '1, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_MBOX_BASE, 32'h8000_0001, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_MBOX_BASE + 13'h4, '1, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_MBOX_BASE, '0, 1'b0, 1'b0);
        drive_access(OP_READ, OFF_MBOX_PEND, '0, 1'b0, 1'b0);
        // Acquire, failed second acquire, ignored release, then a real release.
        drive_access(OP_WRITE, OFF_LOCK_ATTEMPT, '1, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_LOCK_ATTEMPT, 32'h12, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_LOCK_WORD, 32'h8000_0000, 1'b0, 1'b0);
        drive_access(OP_READ, OFF_LOCK_WORD, '0, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_LOCK_WORD, 32'h7fff_ffff, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_ID, '1, 1'b0, 1'b0);
        drive_access(OP_READ, OFF_ID, '0, 1'b0, 1'b0);
        drive_access(OP_READ, 13'h0002, '0, 1'b0, 1'b0);
        drive_access(OP_WRITE, OFF_MBOX_BASE + 13'h8, '1, 1'b0, 1'b0);
        drive_access(OP_PERIPH, '0, '0, 1'b1, 1'b1);
        drive_access(OP_TIMER, '0, '0, 1'b0, 1'b1);
        drive_access(OP_PERIPH, '0, '0, 1'b1, 1'b0);
        drive_access(OP_WRITE, OFF_GLOBAL_MASK, '0, 1'b0, 1'b0);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            for (int n = 0; n < 370; n++) begin
                if (n % 50 == 0) begin
                    idle_on = ($urandom_range(0, 2) != 0);
                end
                random_access();
            end
            drain_results();
        end

        repeat (4) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
